### design/vsb_pkg.sv
// Package for the vertex skinning blend block: payload types, opcodes and constants.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none
package vsb_pkg;
    localparam int PALETTE_BONES_DEF = 256;
    localparam int ONE_Q15 = 32768;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_SKIN = 1'b1
    } t_opcode;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  bone_slot;
        logic [3:0]  elem_index;
        logic signed [31:0] elem_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] nrm_x;
        logic signed [31:0] nrm_y;
        logic signed [31:0] nrm_z;
        logic [31:0] bone_indices;
        logic [47:0] blend_weights;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] skin_pos_x;
        logic signed [31:0] skin_pos_y;
        logic signed [31:0] skin_pos_z;
        logic signed [31:0] skin_nrm_x;
        logic signed [31:0] skin_nrm_y;
        logic signed [31:0] skin_nrm_z;
    } t_out_item;

    // Classified job handed from the front to the back part, a load or a vertex.
    typedef struct packed {
        logic        load;         // palette element write rather than a vertex
        logic        wr_ok;        // load slot is inside the palette
        logic [7:0]  slot;
        logic [3:0]  elem;
        logic signed [31:0] elem_value;
        logic [3:0]  inb;          // influence index is inside the palette
        logic [3:0][7:0] idx;
        logic [3:0][18:0] w;       // each weight is a signed 19-bit value
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] nrm_x;
        logic signed [31:0] nrm_y;
        logic signed [31:0] nrm_z;
    } t_job;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

### design/vsb_if.sv
// Valid/ready channel interfaces for input and result transactions.
// Depends on vsb_pkg for the payload types.
`default_nettype none
interface vsb_in_if;
    logic valid;
    logic ready;
    vsb_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface vsb_out_if;
    logic valid;
    logic ready;
    vsb_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/vsb_front.sv
// Front part: accepts input transactions and classifies them into load or vertex jobs.
// Depends on vsb_pkg. Loads and vertices share one job stream so their order is kept.
`default_nettype none
module vsb_front #(
    parameter int PALETTE_BONES = vsb_pkg::PALETTE_BONES_DEF
) (
    vsb_in_if.sink          i_in,
    input  wire logic       i_job_ready,
    output logic            o_job_valid,
    output vsb_pkg::t_job   o_job
);
    logic [17:0] wsum;
    assign i_in.ready = i_job_ready;
    assign o_job_valid = i_in.valid && i_in.ready;

    assign wsum = 18'(i_in.data.blend_weights[15:0]) + 18'(i_in.data.blend_weights[31:16])
                + 18'(i_in.data.blend_weights[47:32]);

    always_comb begin
        o_job.load = (i_in.data.opcode == vsb_pkg::OP_LOAD);
        o_job.wr_ok = {1'b0, i_in.data.bone_slot} < 9'(PALETTE_BONES);
        o_job.slot = i_in.data.bone_slot;
        o_job.elem = i_in.data.elem_index;
        o_job.elem_value = i_in.data.elem_value;
        o_job.pos_x = i_in.data.pos_x;
        o_job.pos_y = i_in.data.pos_y;
        o_job.pos_z = i_in.data.pos_z;
        o_job.nrm_x = i_in.data.nrm_x;
        o_job.nrm_y = i_in.data.nrm_y;
        o_job.nrm_z = i_in.data.nrm_z;
        for (int k = 0; k < 4; k++) begin
            o_job.idx[k] = i_in.data.bone_indices[8*k +: 8];
            o_job.inb[k] = {1'b0, o_job.idx[k]} < 9'(PALETTE_BONES);
        end
        for (int k = 0; k < 3; k++) begin
            o_job.w[k] = {3'b000, i_in.data.blend_weights[16*k +: 16]};
        end
        // The fourth weight may go negative when the other three exceed one.
        o_job.w[3] = 19'(vsb_pkg::ONE_Q15) - 19'(wsum);
    end
endmodule
`default_nettype wire

### design/vsb_queue.sv
// Short two-entry queue between the front and the back part.
// Depends on vsb_pkg for the job type.
`default_nettype none
module vsb_queue (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  vsb_pkg::t_job i_data,
    output logic          o_ready,
    output logic          o_valid,
    output vsb_pkg::t_job o_data,
    input  wire logic     i_ready
);
    vsb_pkg::t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;
    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

### design/vsb_back.sv
// Back part: palette memory, palette loads, weighted blend of four matrices and the transform.
// Depends on vsb_pkg. Five-stage pipeline with an eight-entry result buffer.
`default_nettype none
module vsb_back #(
    parameter int PALETTE_BONES = vsb_pkg::PALETTE_BONES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_job_valid,
    input  vsb_pkg::t_job   i_job,
    output logic            o_job_ready,
    vsb_out_if.source       o_out
);
    localparam int NE = 12; // elements read: columns 0..2 of rows 0..3
    localparam int AW = (PALETTE_BONES > 1) ? $clog2(PALETTE_BONES) : 1;
    localparam int QD = 8;  // result buffer depth

    logic signed [31:0] r_rd [4][NE];
    // stage valids
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    vsb_pkg::t_job r_j1, r_j2, r_j3;
    logic signed [50:0] r_prod [4][NE];
    logic signed [31:0] r_m [NE];
    logic signed [63:0] r_pp [3][3];
    logic signed [63:0] r_pn [3][3];
    logic signed [31:0] r_tr [3];
    vsb_pkg::t_out_item r_res;
    // result buffer
    vsb_pkg::t_out_item r_q [QD];
    logic [2:0] r_qw, r_qr;
    logic [3:0] r_qc;
    logic [2:0] inflight;
    logic [3:0] tokens;
    logic pop, out_fire, wr_go;

    // Sum of three products plus the scaled translation, rounded half up to Q16.16.
    function automatic logic signed [31:0] round_out(input logic signed [63:0] p0, p1, p2,
                                                     input logic signed [31:0] tr);
        logic signed [66:0] s;
        s = 67'(p0) + 67'(p1) + 67'(p2) + (67'(tr) <<< 16) + 67'sd32768;
        return vsb_pkg::sat32(64'(s >>> 16));
    endfunction

    assign out_fire = o_out.valid && o_out.ready;
    assign inflight = 3'(r_v1) + 3'(r_v2) + 3'(r_v3) + 3'(r_v4) + 3'(r_v5);
    assign tokens = r_qc + 4'(inflight);
    // Accept a job only when every result in flight, and its own, has a buffer slot.
    assign o_job_ready = (tokens < 4'(QD)) || (tokens == 4'(QD) && out_fire);
    assign pop = i_job_valid && o_job_ready;
    assign wr_go = pop && i_job.load && i_job.wr_ok;

    // Each influence and element has its own palette copy, read once a cycle.
    for (genvar b = 0; b < 4; b++) begin : g_bank
        for (genvar r = 0; r < 4; r++) begin : g_row
            for (genvar c = 0; c < 3; c++) begin : g_col
                logic [31:0] r_mem [PALETTE_BONES];
                always_ff @(posedge i_clk) begin
                    if (wr_go && i_job.elem == 4'(r*4 + c)) begin
                        r_mem[i_job.slot[AW-1:0]] <= i_job.elem_value;
                    end
                    r_rd[b][r*3 + c] <= $signed(r_mem[i_job.idx[b][AW-1:0]]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_j1 <= i_job;
        r_j2 <= r_j1;
        r_j3 <= r_j2;
        for (int k = 0; k < 4; k++) begin
            for (int e = 0; e < NE; e++) begin
                r_prod[k][e] <= r_j1.inb[k] ? $signed(r_j1.w[k]) * r_rd[k][e] : 51'sd0;
            end
        end
        for (int e = 0; e < NE; e++) begin
            r_m[e] <= vsb_pkg::sat32((64'(r_prod[0][e]) + 64'(r_prod[1][e])
                      + 64'(r_prod[2][e]) + 64'(r_prod[3][e]) + 64'sd16384) >>> 15);
        end
        // Element row*3+col of the blend; row 3 holds the translation.
        for (int c = 0; c < 3; c++) begin
            r_pp[0][c] <= r_j3.pos_x * r_m[c];
            r_pp[1][c] <= r_j3.pos_y * r_m[3 + c];
            r_pp[2][c] <= r_j3.pos_z * r_m[6 + c];
            r_pn[0][c] <= r_j3.nrm_x * r_m[c];
            r_pn[1][c] <= r_j3.nrm_y * r_m[3 + c];
            r_pn[2][c] <= r_j3.nrm_z * r_m[6 + c];
            r_tr[c] <= r_m[9 + c];
        end
        r_res.skin_pos_x <= round_out(r_pp[0][0], r_pp[1][0], r_pp[2][0], r_tr[0]);
        r_res.skin_pos_y <= round_out(r_pp[0][1], r_pp[1][1], r_pp[2][1], r_tr[1]);
        r_res.skin_pos_z <= round_out(r_pp[0][2], r_pp[1][2], r_pp[2][2], r_tr[2]);
        r_res.skin_nrm_x <= round_out(r_pn[0][0], r_pn[1][0], r_pn[2][0], 32'sd0);
        r_res.skin_nrm_y <= round_out(r_pn[0][1], r_pn[1][1], r_pn[2][1], 32'sd0);
        r_res.skin_nrm_z <= round_out(r_pn[0][2], r_pn[1][2], r_pn[2][2], 32'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (r_v5) begin
            r_q[r_qw] <= r_res;
        end
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_qw <= 3'd0;
            r_qr <= 3'd0;
            r_qc <= 4'd0;
        end else begin
            r_v1 <= pop && !i_job.load;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            if (r_v5) r_qw <= r_qw + 3'd1;
            if (out_fire) r_qr <= r_qr + 3'd1;
            r_qc <= r_qc + 4'(r_v5) - 4'(out_fire);
        end
    end
    assign o_out.valid = r_qc != 4'd0;
    assign o_out.data = r_q[r_qr];
endmodule
`default_nettype wire

### design/vertex_skinning_blend.sv
// Top level of the four-influence linear blend skinning block.
// Depends on vsb_pkg, vsb_if, vsb_front, vsb_queue and vsb_back.
//
//  Channel  Direction  Transaction
//  i_in     sink       palette element load or vertex to skin
//  o_out    source     skinned position and normal, one per vertex
//
// A vertex accepted at the input passes the queue, palette read, weighting, blend,
// transform and rounding stages before its result is valid. A load writes the
// palette when the back part takes it from the queue, in order with the vertices
// around it. Throughput is one transaction per cycle unless the back stalls; every
// palette copy is read once a cycle. Once results in flight plus buffered reach
// the eight-entry result buffer, the back stops taking jobs, the two-entry queue
// fills and the input stalls. Reset is synchronous and active low; the palette is
// not cleared and holds undefined values until written.
`default_nettype none
module vertex_skinning_blend #(
    parameter int PALETTE_BONES = vsb_pkg::PALETTE_BONES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    vsb_in_if.sink    i_in,
    vsb_out_if.source o_out
);
    logic job_valid, job_ready, q_valid, q_ready;
    vsb_pkg::t_job job, q_job;

    vsb_front #(.PALETTE_BONES(PALETTE_BONES)) u_front (
        .i_in,
        .i_job_ready(job_ready), .o_job_valid(job_valid), .o_job(job)
    );
    vsb_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(job_valid), .i_data(job), .o_ready(job_ready),
        .o_valid(q_valid), .o_data(q_job), .i_ready(q_ready)
    );
    vsb_back #(.PALETTE_BONES(PALETTE_BONES)) u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(q_valid), .i_job(q_job), .o_job_ready(q_ready), .o_out
    );

    a_out_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid) else $error("result dropped");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> $stable(o_out.data)) else $error("result changed");
endmodule
`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for vertex_skinning_blend: palette loads and vertex skinning.
// Depends on vsb_pkg and the vsb_in_if / vsb_out_if channel interfaces.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    localparam int NUM_ITEMS = 1600;
    localparam int IDLE_LIMIT = 5000;
    localparam int TAIL_CYCLES = 20;

    // Skinning predictor with its own copy of the bone palette.
    class skin_scoreboard;
        bit [31:0] palette [vsb_pkg::PALETTE_BONES_DEF*16];
        vsb_pkg::t_out_item skinned_q[$];
        int n_errors;
        int n_vertices;
        int n_loads;

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) begin
                return 64'sd2147483647;
            end else if (v < -64'sd2147483648) begin
                return -64'sd2147483648;
            end
            return v;
        endfunction

        // Row-vector transform of one column, rounded half up to Q16.16.
        function longint apply_column(longint vec[3], longint m[16], int col, bit point);
            longint whole;
            longint frac;
            longint prod;
            whole = 0;
            frac = 0;
            for (int r = 0; r < 3; r++) begin
                prod = vec[r] * m[r*4+col];
                whole += prod >>> 16;
                frac += prod & 64'hFFFF;
            end
            if (point) begin
                whole += m[12+col];
            end
            whole += (frac + 32768) >>> 16;
            return clamp32(whole);
        endfunction

        function void note_input(vsb_pkg::t_in_item it);
            longint w[4];
            longint m[16];
            longint pos[3];
            longint nrm[3];
            longint s;
            bit [7:0] idx;
            vsb_pkg::t_out_item res;
            if (it.opcode == vsb_pkg::OP_LOAD) begin
                n_loads++;
                if (it.bone_slot < vsb_pkg::PALETTE_BONES_DEF) begin
                    palette[it.bone_slot*16 + it.elem_index] = it.elem_value;
                end
                return;
            end
            for (int k = 0; k < 3; k++) begin
                w[k] = longint'(it.blend_weights[16*k +: 16]);
            end
            w[3] = vsb_pkg::ONE_Q15 - (w[0] + w[1] + w[2]);
            for (int e = 0; e < 16; e++) begin
                s = 0;
                for (int k = 0; k < 4; k++) begin
                    idx = it.bone_indices[8*k +: 8];
                    if (idx < vsb_pkg::PALETTE_BONES_DEF) begin
                        s += w[k] * longint'($signed(palette[idx*16 + e]));
                    end
                end
                m[e] = clamp32((s + 16384) >>> 15);
            end
            pos[0] = it.pos_x; pos[1] = it.pos_y; pos[2] = it.pos_z;
            nrm[0] = it.nrm_x; nrm[1] = it.nrm_y; nrm[2] = it.nrm_z;
            res.skin_pos_x = 32'(apply_column(pos, m, 0, 1'b1));
            res.skin_pos_y = 32'(apply_column(pos, m, 1, 1'b1));
            res.skin_pos_z = 32'(apply_column(pos, m, 2, 1'b1));
            res.skin_nrm_x = 32'(apply_column(nrm, m, 0, 1'b0));
            res.skin_nrm_y = 32'(apply_column(nrm, m, 1, 1'b0));
            res.skin_nrm_z = 32'(apply_column(nrm, m, 2, 1'b0));
            skinned_q = {skinned_q, res};
        endfunction

        function void check_result(vsb_pkg::t_out_item got);
            vsb_pkg::t_out_item want;
            string names[6] = '{"skin_pos_x", "skin_pos_y", "skin_pos_z",
                                "skin_nrm_x", "skin_nrm_y", "skin_nrm_z"};
            if (skinned_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                n_errors++;
                return;
            end
            want = skinned_q.pop_front();
            n_vertices++;
            for (int i = 0; i < 6; i++) begin
                if (want[32*(5-i) +: 32] !== got[32*(5-i) +: 32]) begin
                    $display("%0t: %s expected %h actual %h", $time, names[i],
                             want[32*(5-i) +: 32], got[32*(5-i) +: 32]);
                    n_errors++;
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    vsb_in_if in_ch ();
    vsb_out_if out_ch ();

    vertex_skinning_blend u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    skin_scoreboard sb = new();
    vsb_pkg::t_in_item stim_q[$];
    bit elem_loaded [vsb_pkg::PALETTE_BONES_DEF*16];
    int full_bones[$];
    int n_sent = 0;
    int idle_cycles = 0;
    bit stim_done;

    // Idle phase rotates every 150 transactions: none, sender, receiver, both.
    function int idle_phase();
        return (n_sent / 150) % 4;
    endfunction

    function bit [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
            case ($urandom_range(0, 4))
                0: return 32'h0;
                1: return 32'h1;
                2: return 32'hFFFFFFFF;
                3: return 32'h7FFFFFFF;
                default: return 32'h80000000;
            endcase
        end else if (sel < 75) begin
            return $urandom_range(0, 32'h80000) - 32'h40000;
        end
        return $urandom;
    endfunction

    function bit [47:0] pick_weights();
        bit [15:0] w0, w1, w2;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            w0 = 16'($urandom_range(0, vsb_pkg::ONE_Q15));
            w1 = 16'($urandom_range(0, vsb_pkg::ONE_Q15 - w0));
            w2 = 16'($urandom_range(0, vsb_pkg::ONE_Q15 - w0 - w1));
        end else if (sel < 7) begin
            w0 = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
            w1 = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
            w2 = $urandom_range(0, 1) ? 16'hFFFF : 16'h8000;
        end else begin
            w0 = 16'($urandom); w1 = 16'($urandom); w2 = 16'($urandom);
        end
        return {w2, w1, w0};
    endfunction

    function vsb_pkg::t_in_item noise_item();
        bit [319:0] raw;
        vsb_pkg::t_in_item it;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom};
        it = raw[$bits(vsb_pkg::t_in_item)-1:0];
        return it;
    endfunction

    function void add_load(int slot, int el, bit [31:0] value);
        vsb_pkg::t_in_item it;
        bit full;
        it = noise_item();
        it.opcode = vsb_pkg::OP_LOAD;
        it.bone_slot = 8'(slot);
        it.elem_index = 4'(el);
        it.elem_value = value;
        stim_q = {stim_q, it};
        elem_loaded[slot*16 + el] = 1'b1;
        full = 1'b1;
        for (int e = 0; e < 16; e++) begin
            full &= elem_loaded[slot*16 + e];
        end
        if (full && !(slot inside {full_bones})) begin
            full_bones = {full_bones, slot};
        end
    endfunction

    // Vertices only reference bones whose sixteen elements have all been loaded.
    function void add_vertex(bit [31:0] px, bit [31:0] py, bit [31:0] pz,
                             bit [47:0] weights);
        vsb_pkg::t_in_item it;
        it = noise_item();
        it.opcode = vsb_pkg::OP_SKIN;
        it.pos_x = px; it.pos_y = py; it.pos_z = pz;
        it.nrm_x = pick_value(); it.nrm_y = pick_value(); it.nrm_z = pick_value();
        for (int k = 0; k < 4; k++) begin
            it.bone_indices[8*k +: 8] =
                8'(full_bones[$urandom_range(0, full_bones.size()-1)]);
        end
        it.blend_weights = weights;
        stim_q = {stim_q, it};
    endfunction

    function void build_stimulus();
        int slot;
        int sel;
        // Directed: an identity-like bone, an extreme-valued bone, then corner vertices.
        for (int e = 0; e < 16; e++) begin
            add_load(0, e, (e % 5 == 0) ? 32'h00010000 : 32'h0);
        end
        for (int e = 0; e < 16; e++) begin
            add_load(255, e, e[0] ? 32'h7FFFFFFF : 32'h80000000);
        end
        add_vertex(32'h7FFFFFFF, 32'h80000000, 32'h0, 48'h0);
        add_vertex(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 48'hFFFF_FFFF_FFFF);
        add_vertex(32'h00010000, 32'h00020000, 32'hFFFF0000, 48'h0000_0000_8000);
        add_vertex(32'h00008000, 32'hFFFF8000, 32'h1, 48'h2000_2000_2000);
        while (stim_q.size() < NUM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 6) begin
                slot = $urandom_range(0, vsb_pkg::PALETTE_BONES_DEF-1);
                for (int e = 0; e < 16; e++) begin
                    add_load(slot, e, pick_value());
                end
            end else if (sel < 12) begin
                add_load($urandom_range(0, vsb_pkg::PALETTE_BONES_DEF-1),
                         $urandom_range(0, 15), pick_value());
            end else begin
                add_vertex(pick_value(), pick_value(), pick_value(), pick_weights());
            end
        end
    endfunction

    // Sender: a transaction stays on the channel until it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                sb.note_input(in_ch.data);
                n_sent++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (stim_q.size() > 0 && !(idle_phase() inside {1, 3} &&
                        $urandom_range(0, 99) < (idle_phase() == 1 ? 72 : 29))) begin
                    in_ch.data <= stim_q.pop_front();
                    in_ch.valid <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                sb.check_result(out_ch.data);
            end
            case (idle_phase())
                2: out_ch.ready <= ($urandom_range(0, 99) >= 72);
                3: out_ch.ready <= ($urandom_range(0, 99) >= 29);
                default: out_ch.ready <= 1'b1;
            endcase
        end
    end

    // Watchdog on cycles in which work is outstanding but nothing moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (stim_done && sb.skinned_q.size() == 0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        stim_done = 1'b0;
        build_stimulus();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_q.size() == 0);
        @(posedge i_clk);
        while (in_ch.valid) @(posedge i_clk);
        stim_done = 1'b1;
        while (sb.skinned_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Accepted %0d loads and %0d vertices; %0d vertex results checked.",
                 sb.n_loads, n_sent - sb.n_loads, sb.n_vertices);
        $display("Idle phases covered: none, sender, receiver and both; %0d mismatches.",
                 sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
